// File: design/sal_pkg.sv
// shared types, constants and round helpers for the salsa20 stream cipher
`timescale 1ns / 1ps

package sal_pkg;

   localparam int DEF_ROUND_COUNT = 20;

   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int BLOCK_BYTES = 64;
   localparam int BYTE_POS_W  = $clog2(BLOCK_BYTES);
   localparam int BYTE_IDX_W  = BYTE_POS_W + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_01 = 3'd0,
      CSR_KEY_23 = 3'd1,
      CSR_KEY_45 = 3'd2,
      CSR_KEY_67 = 3'd3,
      CSR_NONCE  = 3'd4,
      CSR_MODE   = 3'd5
   } csr_idx_type;

   typedef enum logic [3:0] {
      CS_IDLE  = 4'b0001,
      CS_ROUND = 4'b0010,
      CS_FINAL = 4'b0100,
      CS_DONE  = 4'b1000
   } core_state_type;

   typedef struct packed {
      logic [3:0][63:0] key;
      logic [63:0]      nonce;
      logic             key_is_256;
   } cipher_cfg_type;

   typedef struct packed {
      logic                                valid;
      logic [BLOCK_WORDS-1:0][WORD_W-1:0] words;
   } ks_blk_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
   } queue_head_type;

   // "expand 32-byte k" and "expand 16-byte k", word 0 in the low slot
   localparam logic [3:0][WORD_W-1:0] SIGMA =
      {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};
   localparam logic [3:0][WORD_W-1:0] TAU =
      {32'h6b206574, 32'h79622d36, 32'h3120646e, 32'h61707865};

   // quarter-round word positions (a, b, c, d)
   localparam logic [3:0] COL_IDX [4][4] = '{
      '{4'd0,  4'd4,  4'd8,  4'd12},
      '{4'd5,  4'd9,  4'd13, 4'd1},
      '{4'd10, 4'd14, 4'd2,  4'd6},
      '{4'd15, 4'd3,  4'd7,  4'd11}
   };
   localparam logic [3:0] ROW_IDX [4][4] = '{
      '{4'd0,  4'd1,  4'd2,  4'd3},
      '{4'd5,  4'd6,  4'd7,  4'd4},
      '{4'd10, 4'd11, 4'd8,  4'd9},
      '{4'd15, 4'd12, 4'd13, 4'd14}
   };

   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                input logic [4:0] n);
      return (v << n) | (v >> (6'd32 - {1'b0, n}));
   endfunction

   // half a quarter round: first half updates b and c, second half d and a
   function automatic logic [3:0][WORD_W-1:0] quarter_half(
      input logic [3:0][WORD_W-1:0] v, input logic second);
      logic [3:0][WORD_W-1:0] r;
      r = v;
      if (!second) begin
         r[1] = v[1] ^ rotl32(v[0] + v[3], 5'd7);
         r[2] = v[2] ^ rotl32(r[1] + v[0], 5'd9);
      end else begin
         r[3] = v[3] ^ rotl32(v[2] + v[1], 5'd13);
         r[0] = v[0] ^ rotl32(r[3] + v[2], 5'd18);
      end
      return r;
   endfunction

   function automatic logic [BLOCK_WORDS-1:0][WORD_W-1:0] init_words(
      input cipher_cfg_type cfg, input logic [63:0] ctr);
      logic [3:0][WORD_W-1:0]         c;
      logic [7:0][WORD_W-1:0]         k;
      logic [BLOCK_WORDS-1:0][WORD_W-1:0] w;
      c = cfg.key_is_256 ? SIGMA : TAU;
      k = cfg.key;
      w[0]  = c[0];
      w[1]  = k[0];
      w[2]  = k[1];
      w[3]  = k[2];
      w[4]  = k[3];
      w[5]  = c[1];
      w[6]  = cfg.nonce[31:0];
      w[7]  = cfg.nonce[63:32];
      w[8]  = ctr[31:0];
      w[9]  = ctr[63:32];
      w[10] = c[2];
      w[11] = cfg.key_is_256 ? k[4] : k[0];
      w[12] = cfg.key_is_256 ? k[5] : k[1];
      w[13] = cfg.key_is_256 ? k[6] : k[2];
      w[14] = cfg.key_is_256 ? k[7] : k[3];
      w[15] = c[3];
      return w;
   endfunction

endpackage

// File: design/sal_if.sv
// handshake channel interfaces: data in, data out and register writes
`timescale 1ns / 1ps

interface sal_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface sal_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink (input valid, input out_byte, output ready);
endinterface

interface sal_csr_if import sal_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/sal_front.sv
// front end: accepts input words into a short queue
`timescale 1ns / 1ps

module sal_front import sal_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   sal_req_if.sink        req,
   output queue_head_type head,
   input  logic           pop
);

   logic [7:0]             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push;

   assign req.ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;

   assign head.valid     = (count_ff != '0);
   assign head.data_byte = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/sal_core.sv
// keystream generator: iterative salsa20 round unit and block counter
`timescale 1ns / 1ps

module sal_core import sal_pkg::*; #(
   parameter int ROUND_COUNT = DEF_ROUND_COUNT
) (
   input  logic           clock,
   input  logic           reset,
   input  cipher_cfg_type cfg,
   input  logic           flush,
   input  logic           take,
   output ks_blk_type     blk
);

   // two half quarter rounds per round, rounds taken in pairs
   localparam int STEPS = (ROUND_COUNT / 2) * 4;
   localparam int CNT_W = $clog2(STEPS);

   core_state_type                      state_ff, state_in;
   logic [CNT_W-1:0]                    step_ff, step_in;
   logic [63:0]                         ctr_ff, ctr_in;
   logic [BLOCK_WORDS-1:0][WORD_W-1:0] x_ff, x_in;
   logic [BLOCK_WORDS-1:0][WORD_W-1:0] iw;
   logic [BLOCK_WORDS-1:0][WORD_W-1:0] x_rnd;
   logic                                last_step;

   assign iw        = init_words(cfg, ctr_ff);
   assign last_step = (step_ff == CNT_W'(STEPS - 1));

   // one half quarter round on all four quarters; step bit 1 picks rows
   always_comb begin
      logic [BLOCK_WORDS-1:0][WORD_W-1:0] x_col;
      logic [BLOCK_WORDS-1:0][WORD_W-1:0] x_row;
      logic [3:0][WORD_W-1:0]             qc;
      logic [3:0][WORD_W-1:0]             qr;
      x_col = x_ff;
      x_row = x_ff;
      for (int q = 0; q < 4; q++) begin
         qc = {x_ff[COL_IDX[q][3]], x_ff[COL_IDX[q][2]],
               x_ff[COL_IDX[q][1]], x_ff[COL_IDX[q][0]]};
         qr = {x_ff[ROW_IDX[q][3]], x_ff[ROW_IDX[q][2]],
               x_ff[ROW_IDX[q][1]], x_ff[ROW_IDX[q][0]]};
         qc = quarter_half(qc, step_ff[0]);
         qr = quarter_half(qr, step_ff[0]);
         for (int j = 0; j < 4; j++) begin
            x_col[COL_IDX[q][j]] = qc[j];
            x_row[ROW_IDX[q][j]] = qr[j];
         end
      end
      x_rnd = step_ff[1] ? x_row : x_col;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ctr_in   = ctr_ff;
      x_in     = x_ff;
      if (flush) begin
         state_in = CS_IDLE;
         ctr_in   = '0;
      end else begin
         unique case (state_ff)
            CS_IDLE: begin
               x_in     = iw;
               step_in  = '0;
               state_in = CS_ROUND;
            end
            CS_ROUND: begin
               x_in    = x_rnd;
               step_in = step_ff + 1'b1;
               if (last_step) begin
                  state_in = CS_FINAL;
               end
            end
            CS_FINAL: begin
               for (int i = 0; i < BLOCK_WORDS; i++) begin
                  x_in[i] = x_ff[i] + iw[i];
               end
               ctr_in   = ctr_ff + 64'd1;
               state_in = CS_DONE;
            end
            CS_DONE: begin
               if (take) begin
                  state_in = CS_IDLE;
               end
            end
            default: state_in = CS_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         step_ff  <= '0;
         ctr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ctr_ff   <= ctr_in;
      end
   end

   assign blk.valid = (state_ff == CS_DONE);
   assign blk.words = x_ff;

endmodule

// File: design/sal_mixer.sv
// back end: keystream buffer, xor with data and output register
`timescale 1ns / 1ps

module sal_mixer import sal_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           flush,
   input  queue_head_type head,
   output logic           pop,
   input  ks_blk_type     blk,
   output logic           take,
   sal_rsp_if.source      rsp
);

   logic [BLOCK_WORDS-1:0][WORD_W-1:0] ks_ff;
   logic [BYTE_IDX_W-1:0]              idx_ff, idx_in;
   logic                                out_valid_ff, out_valid_in;
   logic [7:0]                          out_byte_ff, out_byte_in;
   logic                                empty;
   logic                                out_free;
   logic                                fire;
   logic [WORD_W-1:0]                   buf_word;
   logic [7:0]                          ks_byte;

   // top bit of the index set means the buffer is used up
   assign empty    = idx_ff[BYTE_IDX_W-1];
   assign out_free = !out_valid_ff || rsp.ready;
   assign fire     = head.valid && out_free && (!empty || blk.valid);
   assign pop      = fire;
   assign take     = fire && empty;

   assign buf_word = ks_ff[idx_ff[BYTE_POS_W-1:2]];
   // a fresh block is consumed from its first byte in the cycle it loads
   assign ks_byte  = empty ? blk.words[0][7:0]
                           : buf_word[{idx_ff[1:0], 3'b000} +: 8];

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      if (fire) begin
         idx_in       = empty ? BYTE_IDX_W'(1) : idx_ff + 1'b1;
         out_valid_in = 1'b1;
         out_byte_in  = head.data_byte ^ ks_byte;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (flush) begin
         idx_in = BYTE_IDX_W'(BLOCK_BYTES);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ks_ff <= blk.words;
      end
      out_byte_ff <= out_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= BYTE_IDX_W'(BLOCK_BYTES);
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.out_byte = out_byte_ff;

endmodule

// File: design/salsa20_stream_cipher.sv
// salsa20 stream cipher top level: register file and block wiring
`timescale 1ns / 1ps

// Salsa20 encrypt/decrypt, one byte per word on req_ch, result on rsp_ch.
// Sustained rate is one byte per cycle while rsp_ch is ready and keystream
// is at hand. Keystream blocks come from a round unit that does half a
// quarter round on all four quarters per cycle, then adds the input words;
// the next block is computed while the current one is being used, so with
// the default round count the refill is hidden behind its 64 bytes. After
// reset or a write to a defined register the counter restarts at zero and
// the first byte waits for the first block. From input to output a byte
// passes through a two-entry input queue and the output register.
// Registers: 0..3 key words in pairs, 4 nonce, 5 key_is_256 (bit 0);
// writes to other indexes are ignored. Write registers only while idle.

module salsa20_stream_cipher import sal_pkg::*; #(
   parameter int ROUND_COUNT = DEF_ROUND_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   sal_req_if.sink    req_ch,
   sal_rsp_if.source  rsp_ch,
   sal_csr_if.sink    csr_ch
);

   cipher_cfg_type cfg_ff, cfg_in;
   logic           flush;
   logic           csr_fire;
   queue_head_type head;
   logic           pop;
   ks_blk_type     blk;
   logic           take;

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;

   always_comb begin
      cfg_in = cfg_ff;
      flush  = 1'b0;
      if (csr_fire) begin
         flush = 1'b1;
         unique case (csr_ch.index)
            CSR_KEY_01: cfg_in.key[0]     = csr_ch.data;
            CSR_KEY_23: cfg_in.key[1]     = csr_ch.data;
            CSR_KEY_45: cfg_in.key[2]     = csr_ch.data;
            CSR_KEY_67: cfg_in.key[3]     = csr_ch.data;
            CSR_NONCE:  cfg_in.nonce      = csr_ch.data;
            CSR_MODE:   cfg_in.key_is_256 = csr_ch.data[0];
            default:    flush             = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key        <= '0;
         cfg_ff.nonce      <= '0;
         cfg_ff.key_is_256 <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sal_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .head  (head),
      .pop   (pop)
   );

   sal_core #(
      .ROUND_COUNT (ROUND_COUNT)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .flush (flush),
      .take  (take),
      .blk   (blk)
   );

   sal_mixer u_mixer (
      .clock (clock),
      .reset (reset),
      .flush (flush),
      .head  (head),
      .pop   (pop),
      .blk   (blk),
      .take  (take),
      .rsp   (rsp_ch)
   );

endmodule
